FILE: rtl/core/vsgqm_pkg.sv
// Package for the voxel slice greedy quad merger.
// Holds the command and result beat types; no dependencies.
package vsgqm_pkg;

    localparam int unsigned KIND_LOAD = 0;
    localparam int unsigned KIND_PULL = 1;

    typedef struct packed {
        logic       kind;
        logic [4:0] cell_x;
        logic [4:0] cell_z;
        logic [3:0] cur_type;
        logic       prev_present;
        logic [3:0] prev_type;
        logic       beyond_last;
    } t_cmd;

    typedef struct packed {
        logic       found;
        logic [4:0] quad_x;
        logic [4:0] quad_z;
        logic [5:0] quad_width;
        logic [5:0] quad_height;
        logic [3:0] face_type;
    } t_res;

endpackage

FILE: rtl/core/voxel_slice_greedy_quad_merger_core.sv
// Top level of the voxel slice greedy quad merger: skip-type register,
// sequencer and face mask memory. Depends on vsgqm_pkg, vsgqm_seq, vsgqm_mask_mem.
//
//   channel   direction  handshake                     beat
//   command   in         start & !busy                 i_cmd  (t_cmd)
//   result    out        o_res_strobe, one cycle       o_res  (t_res)
//   config    in         i_cfg_valid & o_cfg_ready     i_cfg_data (skip type)
//
// A load beat is written to the mask as it is accepted; busy stays low.
// A pull beat scans for the next filled cell, grows the run in x, then grows rows in z,
// and clears the width*height cells, all through the one mask memory port pair.
// Done pulls scan the remaining cells. The strobe rises in the same cycle that busy falls.
// Reset clears control state and sets the skip type to 2; the mask needs loading.
// Results cannot be stalled: the strobe is a single cycle.
module voxel_slice_greedy_quad_merger_core #(
    parameter int SIDE      = 32,
    parameter int TYPE_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  vsgqm_pkg::t_cmd    i_cmd,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    output logic               o_res_strobe,
    output vsgqm_pkg::t_res    o_res
);
    import vsgqm_pkg::*;

    localparam int AW = $clog2(SIDE * SIDE);
    localparam int DW = TYPE_BITS + 1;

    logic [3:0]    r_skip_type;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_type <= 4'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_skip_type <= i_cfg_data;
        end
    end

    vsgqm_seq #(
        .SIDE      (SIDE),
        .TYPE_BITS (TYPE_BITS),
        .AW        (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_skip_type  (r_skip_type),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    vsgqm_mask_mem #(
        .AW (AW),
        .DW (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: rtl/core/vsgqm_mask_mem.sv
// Face mask memory: one write port, one read port, registered read data.
// No dependencies.
module vsgqm_mask_mem #(
    parameter int AW = 10,
    parameter int DW = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/vsgqm_seq.sv
// Load/scan/grow/clear sequencer around the face mask memory.
// Depends on vsgqm_pkg; drives the ports of vsgqm_mask_mem.
module vsgqm_seq #(
    parameter int SIDE      = 32,
    parameter int TYPE_BITS = 4,
    parameter int AW        = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  vsgqm_pkg::t_cmd        i_cmd,
    input  logic [3:0]             i_skip_type,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output logic [TYPE_BITS:0]     o_mem_wdata,
    output logic                   o_mem_re,
    output logic [AW-1:0]          o_mem_raddr,
    input  logic [TYPE_BITS:0]     i_mem_rdata,
    output logic                   o_res_strobe,
    output vsgqm_pkg::t_res        o_res
);
    import vsgqm_pkg::*;

    localparam int XB = $clog2(SIDE);
    localparam int WB = $clog2(SIDE + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_GROWX = 3'd2;
    localparam logic [2:0] S_GROWZ = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]           r_state;
    logic [XB-1:0]        r_scan_x, r_scan_z;
    logic                 r_scan_end;
    logic [XB-1:0]        r_px, r_pz, r_ax, r_az, r_x, r_z;
    logic                 r_pe, r_pend;
    logic [TYPE_BITS-1:0] r_t;
    logic [WB-1:0]        r_w, r_h, r_k, r_j;
    logic                 r_res_stb;
    t_res                 r_res;

    logic [7:0]           cur8, prv8, skp8, t8;
    logic [TYPE_BITS-1:0] cur_t, prv_t, skp_t;
    logic                 ld_in_range, ld_filled, rd_vld, rd_match, accept;
    logic                 gx_ok, gz_ok, scan_last, pz_last;
    int                   gx_sum, gz_row;
    logic [AW-1:0]        ld_addr, scan_addr, gx_addr, gz_addr, cl_addr;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    assign cur8  = 8'(i_cmd.cur_type);
    assign prv8  = 8'(i_cmd.prev_type);
    assign skp8  = 8'(i_skip_type);
    assign cur_t = cur8[TYPE_BITS-1:0];
    assign prv_t = prv8[TYPE_BITS-1:0];
    assign skp_t = skp8[TYPE_BITS-1:0];
    assign t8    = 8'(r_t);

    assign ld_in_range = (int'(i_cmd.cell_x) < SIDE) && (int'(i_cmd.cell_z) < SIDE);
    assign ld_filled   = !i_cmd.beyond_last && (cur_t != skp_t)
                         && !(i_cmd.prev_present && (prv_t == cur_t));

    assign rd_vld   = i_mem_rdata[TYPE_BITS];
    assign rd_match = rd_vld && (i_mem_rdata[TYPE_BITS-1:0] == r_t);

    assign gx_sum = int'(r_x) + int'(r_w);
    assign gz_row = int'(r_z) + int'(r_h);
    assign gx_ok  = gx_sum < SIDE;
    assign gz_ok  = gz_row < SIDE;

    assign pz_last   = (int'(r_pz) == SIDE - 1);
    assign scan_last = (int'(r_px) == SIDE - 1) && pz_last;

    assign ld_addr   = AW'(int'(i_cmd.cell_x) * SIDE + int'(i_cmd.cell_z));
    assign scan_addr = AW'(int'(r_px) * SIDE + int'(r_pz));
    assign gx_addr   = AW'(gx_sum * SIDE + int'(r_z));
    assign gz_addr   = AW'((int'(r_x) + int'(r_k)) * SIDE + gz_row);
    assign cl_addr   = AW'((int'(r_x) + int'(r_k)) * SIDE + int'(r_z) + int'(r_j));

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = ld_addr;
        o_mem_wdata = ld_filled ? {1'b1, cur_t} : '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = scan_addr;
        case (r_state)
            S_IDLE: begin
                o_mem_we = accept && (i_cmd.kind == 1'(KIND_LOAD)) && ld_in_range;
            end
            S_SCAN: begin
                o_mem_re = !(r_pend && rd_vld) && !r_pe;
            end
            S_GROWX: begin
                o_mem_re    = !r_pend && gx_ok;
                o_mem_raddr = gx_addr;
            end
            S_GROWZ: begin
                o_mem_re    = !r_pend && gz_ok;
                o_mem_raddr = gz_addr;
            end
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = cl_addr;
                o_mem_wdata = '0;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res_stb <= 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.kind == 1'(KIND_LOAD)) begin
                        r_scan_x   <= '0;
                        r_scan_z   <= '0;
                        r_scan_end <= 1'b0;
                    end else begin
                        r_px    <= r_scan_x;
                        r_pz    <= r_scan_z;
                        r_pe    <= r_scan_end;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && rd_vld) begin
                    r_x    <= r_ax;
                    r_z    <= r_az;
                    r_t    <= i_mem_rdata[TYPE_BITS-1:0];
                    r_w    <= WB'(1);
                    r_pend <= 1'b0;
                    r_state <= S_GROWX;
                    if ((int'(r_ax) == SIDE - 1) && (int'(r_az) == SIDE - 1)) begin
                        r_scan_end <= 1'b1;
                    end else if (int'(r_az) == SIDE - 1) begin
                        r_scan_x <= r_ax + XB'(1);
                        r_scan_z <= '0;
                    end else begin
                        r_scan_x <= r_ax;
                        r_scan_z <= r_az + XB'(1);
                    end
                end else if (r_pe) begin
                    r_scan_end <= 1'b1;
                    r_res_stb  <= 1'b1;
                    r_res      <= '0;
                    r_pend     <= 1'b0;
                    r_state    <= S_IDLE;
                end else begin
                    r_ax   <= r_px;
                    r_az   <= r_pz;
                    r_pend <= 1'b1;
                    r_pe   <= scan_last;
                    if (pz_last) begin
                        r_px <= r_px + XB'(1);
                        r_pz <= '0;
                    end else begin
                        r_pz <= r_pz + XB'(1);
                    end
                end
            end
            S_GROWX: begin
                if (!r_pend) begin
                    if (gx_ok) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_h     <= WB'(1);
                        r_k     <= '0;
                        r_state <= S_GROWZ;
                    end
                end else begin
                    r_pend <= 1'b0;
                    if (rd_match) begin
                        r_w <= r_w + WB'(1);
                    end else begin
                        r_h     <= WB'(1);
                        r_k     <= '0;
                        r_state <= S_GROWZ;
                    end
                end
            end
            S_GROWZ: begin
                if (!r_pend) begin
                    if (gz_ok) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_CLEAR;
                    end
                end else begin
                    r_pend <= 1'b0;
                    if (!rd_match) begin
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_CLEAR;
                    end else if (r_k + WB'(1) == r_w) begin
                        r_k <= '0;
                        r_h <= r_h + WB'(1);
                    end else begin
                        r_k <= r_k + WB'(1);
                    end
                end
            end
            S_CLEAR: begin
                if (r_j + WB'(1) == r_h) begin
                    r_j <= '0;
                    if (r_k + WB'(1) == r_w) begin
                        r_res_stb         <= 1'b1;
                        r_res.found       <= 1'b1;
                        r_res.quad_x      <= 5'(r_x);
                        r_res.quad_z      <= 5'(r_z);
                        r_res.quad_width  <= 6'(r_w);
                        r_res.quad_height <= 6'(r_h);
                        r_res.face_type   <= t8[3:0];
                        r_state           <= S_IDLE;
                    end else begin
                        r_k <= r_k + WB'(1);
                    end
                end else begin
                    r_j <= r_j + WB'(1);
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_x   <= '0;
            r_scan_z   <= '0;
            r_scan_end <= 1'b0;
            r_pend     <= 1'b0;
            r_pe       <= 1'b0;
            r_res_stb  <= 1'b0;
        end
    end

    assign o_res_strobe = r_res_stb;
    assign o_res        = r_res;

endmodule

FILE: dv/voxel_slice_greedy_quad_merger_core_tb.sv
// Testbench for voxel_slice_greedy_quad_merger_core: loads face masks and pulls merged quads,
// checking every result against an in-bench greedy merge predictor.
// Depends on vsgqm_pkg and the core RTL only.
`timescale 1ns / 1ps

module voxel_slice_greedy_quad_merger_core_tb;
    import vsgqm_pkg::*;

    localparam int SIDE     = 32;
    localparam int CELLS    = SIDE * SIDE;
    localparam int CMD_BITS = $bits(t_cmd);

    class quad_mirror;
        bit       filled[CELLS];
        bit [3:0] cell_type[CELLS];
        int       scan_at;
        bit [3:0] skip_type;
        bit       slice_drained;
        int       mismatches;
        t_res     pending_quads[$];

        function new();
            scan_at       = 0;
            skip_type     = 4'd2;
            slice_drained = 1'b0;
            mismatches    = 0;
            foreach (filled[i]) begin
                filled[i]    = 1'b0;
                cell_type[i] = 4'd0;
            end
        endfunction

        function bit same_cell(int x, int z, bit [3:0] t);
            return filled[x * SIDE + z] && cell_type[x * SIDE + z] == t;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void note_cmd(t_cmd c);
            int       pos;
            int       x;
            int       z;
            int       w;
            int       h;
            int       idx;
            bit [3:0] t;
            bit       row_ok;
            bit       keep;
            t_res     q;
            if (c.kind == KIND_LOAD) begin
                scan_at       = 0;
                slice_drained = 1'b0;
                if (int'(c.cell_x) < SIDE && int'(c.cell_z) < SIDE) begin
                    idx  = int'(c.cell_x) * SIDE + int'(c.cell_z);
                    keep = !c.beyond_last && c.cur_type != skip_type
                           && !(c.prev_present && c.prev_type == c.cur_type);
                    filled[idx]    = keep;
                    cell_type[idx] = keep ? c.cur_type : 4'd0;
                end
                return;
            end
            q   = '0;
            pos = scan_at;
            while (pos < CELLS && !filled[pos]) begin
                pos++;
            end
            if (pos >= CELLS) begin
                scan_at       = CELLS;
                slice_drained = 1'b1;
            end else begin
                x = pos / SIDE;
                z = pos % SIDE;
                t = cell_type[pos];
                w = 1;
                while (x + w < SIDE && same_cell(x + w, z, t)) begin
                    w++;
                end
                h = 1;
                row_ok = 1'b1;
                while (z + h < SIDE && row_ok) begin
                    for (int k = 0; k < w; k++) begin
                        if (!same_cell(x + k, z + h, t)) begin
                            row_ok = 1'b0;
                        end
                    end
                    if (row_ok) begin
                        h++;
                    end
                end
                for (int k = 0; k < w; k++) begin
                    for (int j = 0; j < h; j++) begin
                        filled[(x + k) * SIDE + z + j]    = 1'b0;
                        cell_type[(x + k) * SIDE + z + j] = 4'd0;
                    end
                end
                scan_at       = pos + 1;
                q.found       = 1'b1;
                q.quad_x      = 5'(x);
                q.quad_z      = 5'(z);
                q.quad_width  = 6'(w);
                q.quad_height = 6'(h);
                q.face_type   = t;
            end
            pending_quads = {pending_quads, q};
        endfunction

        function void check_quad(t_res r);
            t_res e;
            if (pending_quads.size() == 0) begin
                flag($sformatf("unexpected quad beat: %p", r));
                return;
            end
            e = pending_quads.pop_front();
            if (r.found !== e.found || r.quad_x !== e.quad_x || r.quad_z !== e.quad_z
                || r.quad_width !== e.quad_width || r.quad_height !== e.quad_height
                || r.face_type !== e.face_type) begin
                flag($sformatf("quad mismatch: expected %p, got %p", e, r));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [3:0] i_cfg_data;
    logic o_res_strobe;
    t_res o_res;

    quad_mirror mirror = new();
    int items_sent = 0;
    int idle_mode  = 1;

    voxel_slice_greedy_quad_merger_core #(
        .SIDE      (SIDE),
        .TYPE_BITS (4)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            mirror.check_quad(o_res);
        end
    end

    function int draw_gap();
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 16);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    task automatic send_cmd(t_cmd c);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd <= c;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        mirror.note_cmd(c);
        items_sent++;
    endtask

    task automatic load_cell(int x, int z, bit [3:0] t, bit pp, bit [3:0] pt, bit bl);
        t_cmd c;
        c              = '0;
        c.kind         = 1'(KIND_LOAD);
        c.cell_x       = 5'(x);
        c.cell_z       = 5'(z);
        c.cur_type     = t;
        c.prev_present = pp;
        c.prev_type    = pt;
        c.beyond_last  = bl;
        send_cmd(c);
    endtask

    // pull beats carry random filler in the unused fields
    task automatic pull_quad();
        t_cmd c;
        c      = CMD_BITS'($urandom);
        c.kind = 1'(KIND_PULL);
        send_cmd(c);
    endtask

    task automatic noise_load();
        t_cmd c;
        c      = CMD_BITS'($urandom);
        c.kind = 1'(KIND_LOAD);
        send_cmd(c);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (mirror.pending_quads.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_skip(bit [3:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mirror.skip_type = v;
    endtask

    initial begin : stimulus
        int slice_no;
        int fill_items;
        int x0;
        int z0;
        int w;
        int h;
        int pulls;
        bit [3:0] t;
        bit       pp;
        bit [3:0] pt;
        bit       bl;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 4'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // whole slice of one type: a single 32x32 quad, then done twice
        for (int x = 0; x < SIDE; x++) begin
            for (int z = 0; z < SIDE; z++) begin
                load_cell(x, z, 4'd7, 1'b0, 4'($urandom_range(0, 15)), 1'b0);
            end
        end
        pull_quad();
        pull_quad();
        pull_quad();

        // load rules at the reset skip type, corner cells, rewind between pulls
        load_cell(0, 0, 4'd15, 1'b0, 4'd0, 1'b0);
        load_cell(1, 0, 4'd15, 1'b0, 4'd0, 1'b0);
        load_cell(0, 1, 4'd15, 1'b1, 4'd3, 1'b0);
        load_cell(1, 1, 4'd15, 1'b0, 4'd15, 1'b0);
        load_cell(31, 31, 4'd0, 1'b0, 4'd0, 1'b0);
        load_cell(31, 0, 4'd2, 1'b0, 4'd0, 1'b0);
        load_cell(30, 5, 4'd9, 1'b1, 4'd9, 1'b0);
        load_cell(29, 5, 4'd9, 1'b1, 4'd3, 1'b0);
        load_cell(28, 5, 4'd9, 1'b0, 4'd0, 1'b1);
        pull_quad();
        load_cell(5, 5, 4'd4, 1'b0, 4'd0, 1'b0);
        pull_quad();
        pull_quad();
        pull_quad();
        pull_quad();
        fill_items = items_sent;

        slice_no = 0;
        while (items_sent < fill_items + 250) begin
            slice_no++;
            wait_idle();
            if (slice_no == 1) begin
                write_skip(4'd0);
            end else if (slice_no == 2) begin
                write_skip(4'd15);
            end else if ($urandom_range(0, 2) == 0) begin
                write_skip(4'($urandom_range(0, 15)));
            end
            idle_mode = $urandom_range(0, 3);

            repeat ($urandom_range(1, 5)) begin
                x0 = $urandom_range(0, SIDE - 1);
                z0 = $urandom_range(0, SIDE - 1);
                if ($urandom_range(0, 9) == 0) begin
                    w = $urandom_range(1, SIDE);
                    h = $urandom_range(1, 12);
                end else begin
                    w = $urandom_range(1, 4);
                    h = $urandom_range(1, 4);
                end
                t = 4'($urandom_range(0, 15));
                for (int i = 0; i < w && x0 + i < SIDE; i++) begin
                    for (int j = 0; j < h && z0 + j < SIDE; j++) begin
                        pp = 1'($urandom_range(0, 1));
                        pt = ($urandom_range(0, 7) == 0) ? t : 4'($urandom_range(0, 15));
                        bl = ($urandom_range(0, 31) == 0);
                        load_cell(x0 + i, z0 + j, t, pp, pt, bl);
                    end
                end
            end
            repeat ($urandom_range(0, 3)) noise_load();

            pulls = 0;
            while (!mirror.slice_drained && pulls < 200) begin
                if ($urandom_range(0, 11) == 0) begin
                    noise_load();
                end
                pull_quad();
                pulls++;
                if ($urandom_range(0, 15) == 0) begin
                    break;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                pull_quad();
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mirror.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
